### design/kmeans_color_clustering_macros.svh
// Assertion macros shared by the colour clustering RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef KMEANS_COLOR_CLUSTERING_MACROS_SVH
`define KMEANS_COLOR_CLUSTERING_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define KCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define KCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kcc_pkg.sv
// Shared constants, types and helpers for the colour clustering block.
// No dependencies; imported by kcc_divider, kcc_l1dist and the top level.
package kcc_pkg;

    localparam int MAX_PIXELS   = 4096;
    localparam int PIX_AW       = $clog2(MAX_PIXELS);
    localparam int CNT_W        = PIX_AW + 1;
    localparam int MAX_CLUSTERS = 16;
    localparam int CL_W         = $clog2(MAX_CLUSTERS);
    localparam int K_W          = CL_W + 1;
    localparam int CHAN_W       = 8;
    localparam int PIX_W        = 3 * CHAN_W;
    localparam int SUM_W        = CHAN_W + PIX_AW;
    localparam int DIST_W       = CHAN_W + 2;
    localparam int ITER_W       = 10;
    localparam int SEED_W       = 32;
    localparam int DIV_W        = 32;
    localparam int DIV_CW       = $clog2(DIV_W);
    localparam int OUT_W        = 40;

    localparam logic [SEED_W-1:0] LFSR_MASK       = 32'h8020_0003;
    localparam logic [K_W-1:0]    RST_CLUSTERS    = 5'd4;
    localparam logic [ITER_W-1:0] RST_MAX_ITER    = 10'd800;
    localparam logic [SEED_W-1:0] RST_SEED        = 32'd1;

    localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [1:0] CFG_MAX_ITER      = 2'd1;
    localparam logic [1:0] CFG_RANDOM_SEED   = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } kcc_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } kcc_div_stat_t;

    // one Galois step, shifting right
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage

### design/kcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/kcc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on kcc_pkg.
module kcc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kcc_pkg::kcc_div_req_t       req,
    output kcc_pkg::kcc_div_stat_t      stat,
    output logic [kcc_pkg::DIV_W-1:0]   quotient,
    output logic [kcc_pkg::CNT_W-1:0]   remainder
);
    import kcc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                quo_next  = req.dividend;
                rem_next  = '0;
                dvs_next  = req.divisor;
            end
        end
        else
        begin
            // remainder stays below divisor, so the trial fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### design/kcc_l1dist.sv
// L1 distance between a pixel and a centre, three byte channels.
// Depends on kcc_pkg.
module kcc_l1dist (
    input  logic [kcc_pkg::PIX_W-1:0]  pixel,
    input  logic [kcc_pkg::PIX_W-1:0]  centre,
    output logic [kcc_pkg::DIST_W-1:0] dist_sum
);
    import kcc_pkg::*;

    logic [CHAN_W-1:0] diff [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (pixel[c*CHAN_W +: CHAN_W] > centre[c*CHAN_W +: CHAN_W])
            begin
                diff[c] = pixel[c*CHAN_W +: CHAN_W] - centre[c*CHAN_W +: CHAN_W];
            end
            else
            begin
                diff[c] = centre[c*CHAN_W +: CHAN_W] - pixel[c*CHAN_W +: CHAN_W];
            end
        end
        dist_sum = DIST_W'(diff[0]) + DIST_W'(diff[1]) + DIST_W'(diff[2]);
    end

endmodule

### design/kmeans_color_clustering.sv
// Top level of the colour clustering block: sequencer, centre and sum storage.
// Depends on kcc_pkg, kcc_ram, kcc_divider, kcc_l1dist and the macros header.
//
// Pixels stream in one per cycle while the block is idle and are written to
// a 4096-entry pixel RAM (pixels past the 4096th are dropped). The transfer
// with tlast set starts a k-means run with L1 distance; s_axis_tready stays
// low until all k centres have been sent. Seeding handles one centre at a
// time: an LFSR draw, a 32-step modulo on the shared divider, its done
// state, the RAM read at the remainder and the centre write. Each iteration
// walks the stored pixels, one pixel at a time, comparing it against one
// centre per cycle on a single distance unit. The centre update then runs
// the same shared divider three times per non-empty cluster, once per
// channel, and three LFSR draws for an empty one. The run stops on
// convergence or at max_iterations; k centres then leave in index order,
// one per transfer, the last one with tlast. No clearing pass follows reset.
`include "kmeans_color_clustering_macros.svh"
module kmeans_color_clustering (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [kcc_pkg::PIX_W-1:0]   s_axis_tdata,  // pixel_blue, pixel_green, pixel_red
    input  logic                        s_axis_tlast,  // last_pixel
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // cluster_index, centre_blue, centre_green, centre_red, iterations_used,
    // converged, zero pad
    output logic [kcc_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast,  // last_centre
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_addr,
    input  logic [kcc_pkg::SEED_W-1:0]  cfg_wdata
);
    import kcc_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_SEED_DRW = 15'b000000000000010,
        ST_SEED_WT  = 15'b000000000000100,
        ST_SEED_RD  = 15'b000000000001000,
        ST_SEED_WR  = 15'b000000000010000,
        ST_ITER     = 15'b000000000100000,
        ST_PIX_RD   = 15'b000000001000000,
        ST_PIX_CMP  = 15'b000000010000000,
        ST_PIX_ACC  = 15'b000000100000000,
        ST_UPD_CHK  = 15'b000001000000000,
        ST_UPD_RND  = 15'b000010000000000,
        ST_UPD_DST  = 15'b000100000000000,
        ST_UPD_DWT  = 15'b001000000000000,
        ST_UPD_WR   = 15'b010000000000000,
        ST_EMIT     = 15'b100000000000000
    } kcc_state_t;

    // control
    kcc_state_t         state_reg, state_next;
    logic [K_W-1:0]     ccount_reg, ccount_next;
    logic [ITER_W-1:0]  maxit_reg, maxit_next;
    logic [SEED_W-1:0]  lfsr_reg, lfsr_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [ITER_W-1:0]  limit_reg, limit_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [K_W-1:0]     tally_reg, tally_next;
    logic [CL_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [1:0]         ch_reg, ch_next;
    logic               mvalid_reg, mvalid_next;

    // payload
    logic [PIX_AW-1:0]  addr_reg, addr_next;
    logic [CL_W-1:0]    best_reg, best_next;
    logic [DIST_W-1:0]  bestd_reg, bestd_next;
    logic [PIX_W-1:0]   nc_reg, nc_next;
    logic [OUT_W-1:0]   mdata_reg, mdata_next;
    logic               mlast_reg, mlast_next;
    logic [PIX_W-1:0]   centre_reg [MAX_CLUSTERS];
    logic [PIX_W-1:0]   centre_next [MAX_CLUSTERS];
    logic [SUM_W-1:0]   sum_reg [MAX_CLUSTERS][3];
    logic [SUM_W-1:0]   sum_next [MAX_CLUSTERS][3];
    logic [CNT_W-1:0]   count_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]   count_next [MAX_CLUSTERS];

    logic               in_xfer;
    logic               out_xfer;
    logic               r_last;
    logic [SEED_W-1:0]  lfsr_adv;
    logic [PIX_W-1:0]   ram_rdata;
    logic [DIST_W-1:0]  pix_dist;
    kcc_div_req_t       div_req;
    kcc_div_stat_t      div_stat;
    logic [DIV_W-1:0]   div_quo;
    logic [CNT_W-1:0]   div_rem;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign r_last   = ({1'b0, r_reg} == k_reg - 1'b1);
    assign lfsr_adv = lfsr_step(lfsr_reg);

    kcc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (in_xfer && (total_reg < CNT_W'(MAX_PIXELS))),
        .waddr (total_reg[PIX_AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    kcc_l1dist u_dist (
        .pixel    (ram_rdata),
        .centre   (centre_reg[r_reg]),
        .dist_sum (pix_dist)
    );

    // shared divider: pixel index draw during seeding, channel means in update
    always_comb
    begin
        div_req.start    = (state_reg == ST_SEED_DRW) || (state_reg == ST_UPD_DST);
        div_req.dividend = DIV_W'(sum_reg[r_reg][ch_reg]);
        div_req.divisor  = count_reg[r_reg];
        if (state_reg == ST_SEED_DRW)
        begin
            div_req.dividend = lfsr_adv;
            div_req.divisor  = total_reg;
        end
    end

    kcc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        ccount_next = ccount_reg;
        maxit_next  = maxit_reg;
        lfsr_next   = lfsr_reg;
        total_next  = total_reg;
        k_next      = k_reg;
        limit_next  = limit_reg;
        iter_next   = iter_reg;
        tally_next  = tally_reg;
        r_next      = r_reg;
        i_next      = i_reg;
        ch_next     = ch_reg;
        mvalid_next = mvalid_reg;
        addr_next   = addr_reg;
        best_next   = best_reg;
        bestd_next  = bestd_reg;
        nc_next     = nc_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        centre_next = centre_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;

        // register writes must come only while idle; the block itself does not enforce it
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_CLUSTER_COUNT: ccount_next = cfg_wdata[K_W-1:0];
                CFG_MAX_ITER:      maxit_next  = cfg_wdata[ITER_W-1:0];
                CFG_RANDOM_SEED:   lfsr_next   = (cfg_wdata == '0) ? RST_SEED : cfg_wdata;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (total_reg < CNT_W'(MAX_PIXELS))
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        if (ccount_reg == '0)
                        begin
                            k_next = K_W'(1);
                        end
                        else if (ccount_reg > K_W'(MAX_CLUSTERS))
                        begin
                            k_next = K_W'(MAX_CLUSTERS);
                        end
                        else
                        begin
                            k_next = ccount_reg;
                        end
                        limit_next = (maxit_reg == '0) ? ITER_W'(1) : maxit_reg;
                        r_next     = '0;
                        state_next = ST_SEED_DRW;
                    end
                end
            end
            ST_SEED_DRW:
            begin
                lfsr_next  = lfsr_adv;
                state_next = ST_SEED_WT;
            end
            ST_SEED_WT:
            begin
                if (div_stat.done)
                begin
                    addr_next  = div_rem[PIX_AW-1:0];
                    state_next = ST_SEED_RD;
                end
            end
            ST_SEED_RD:
            begin
                state_next = ST_SEED_WR;
            end
            ST_SEED_WR:
            begin
                centre_next[r_reg] = ram_rdata;
                if (r_last)
                begin
                    iter_next  = '0;
                    tally_next = '0;
                    state_next = ST_ITER;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_SEED_DRW;
                end
            end
            ST_ITER:
            begin
                if ((iter_reg < limit_reg) && (tally_reg < k_reg))
                begin
                    iter_next  = iter_reg + 1'b1;
                    tally_next = '0;
                    for (int n = 0; n < MAX_CLUSTERS; n++)
                    begin
                        count_next[n] = '0;
                        for (int c = 0; c < 3; c++)
                        begin
                            sum_next[n][c] = '0;
                        end
                    end
                    i_next     = '0;
                    addr_next  = '0;
                    r_next     = '0;
                    state_next = ST_PIX_RD;
                end
                else
                begin
                    r_next      = '0;
                    mvalid_next = 1'b1;
                    mdata_next  = {1'b0, (tally_reg >= k_reg), iter_reg, centre_reg[0],
                                   CL_W'(0)};
                    mlast_next  = (k_reg == K_W'(1));
                    state_next  = ST_EMIT;
                end
            end
            ST_PIX_RD:
            begin
                state_next = ST_PIX_CMP;
            end
            ST_PIX_CMP:
            begin
                // ties keep the lower index
                if ((r_reg == '0) || (pix_dist < bestd_reg))
                begin
                    bestd_next = pix_dist;
                    best_next  = r_reg;
                end
                if (r_last)
                begin
                    state_next = ST_PIX_ACC;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_PIX_ACC:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_next[best_reg][c] = sum_reg[best_reg][c]
                                          + SUM_W'(ram_rdata[c*CHAN_W +: CHAN_W]);
                end
                count_next[best_reg] = count_reg[best_reg] + 1'b1;
                r_next = '0;
                if (i_reg == total_reg - 1'b1)
                begin
                    state_next = ST_UPD_CHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    addr_next  = PIX_AW'(i_reg + 1'b1);
                    state_next = ST_PIX_RD;
                end
            end
            ST_UPD_CHK:
            begin
                ch_next = '0;
                if (count_reg[r_reg] == '0)
                begin
                    state_next = ST_UPD_RND;
                end
                else
                begin
                    state_next = ST_UPD_DST;
                end
            end
            ST_UPD_RND:
            begin
                // empty cluster: one draw per byte, blue first
                lfsr_next = lfsr_adv;
                case (ch_reg)
                    2'd0:    nc_next[0 +: CHAN_W]        = lfsr_adv[CHAN_W-1:0];
                    2'd1:    nc_next[CHAN_W +: CHAN_W]   = lfsr_adv[CHAN_W-1:0];
                    default: nc_next[2*CHAN_W +: CHAN_W] = lfsr_adv[CHAN_W-1:0];
                endcase
                if (ch_reg == 2'd2)
                begin
                    centre_next[r_reg] = {lfsr_adv[CHAN_W-1:0], nc_reg[2*CHAN_W-1:0]};
                    if (r_last)
                    begin
                        state_next = ST_ITER;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_UPD_CHK;
                    end
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_UPD_DST:
            begin
                state_next = ST_UPD_DWT;
            end
            ST_UPD_DWT:
            begin
                if (div_stat.done)
                begin
                    case (ch_reg)
                        2'd0:    nc_next[0 +: CHAN_W]        = div_quo[CHAN_W-1:0];
                        2'd1:    nc_next[CHAN_W +: CHAN_W]   = div_quo[CHAN_W-1:0];
                        default: nc_next[2*CHAN_W +: CHAN_W] = div_quo[CHAN_W-1:0];
                    endcase
                    if (ch_reg == 2'd2)
                    begin
                        state_next = ST_UPD_WR;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_UPD_DST;
                    end
                end
            end
            ST_UPD_WR:
            begin
                if (nc_reg == centre_reg[r_reg])
                begin
                    tally_next = tally_reg + 1'b1;
                end
                centre_next[r_reg] = nc_reg;
                if (r_last)
                begin
                    state_next = ST_ITER;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_UPD_CHK;
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (mlast_reg)
                    begin
                        mvalid_next = 1'b0;
                        total_next  = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        mdata_next = {mdata_reg[OUT_W-1:CL_W+PIX_W],
                                      centre_reg[r_reg + 1'b1], CL_W'(r_reg + 1'b1)};
                        mlast_next = ({1'b0, r_reg} + 2'd2 == {1'b0, k_reg});
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ccount_reg <= RST_CLUSTERS;
            maxit_reg  <= RST_MAX_ITER;
            lfsr_reg   <= RST_SEED;
            total_reg  <= '0;
            k_reg      <= RST_CLUSTERS;
            limit_reg  <= RST_MAX_ITER;
            iter_reg   <= '0;
            tally_reg  <= '0;
            r_reg      <= '0;
            i_reg      <= '0;
            ch_reg     <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ccount_reg <= ccount_next;
            maxit_reg  <= maxit_next;
            lfsr_reg   <= lfsr_next;
            total_reg  <= total_next;
            k_reg      <= k_next;
            limit_reg  <= limit_next;
            iter_reg   <= iter_next;
            tally_reg  <= tally_next;
            r_reg      <= r_next;
            i_reg      <= i_next;
            ch_reg     <= ch_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        best_reg   <= best_next;
        bestd_reg  <= bestd_next;
        nc_reg     <= nc_next;
        mdata_reg  <= mdata_next;
        mlast_reg  <= mlast_next;
        centre_reg <= centre_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;

    `KCC_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid, "input open while emitting")
    `KCC_ASSERT_IMP(a_out_in_emit, m_axis_tvalid, state_reg == ST_EMIT, "output valid outside emit")
    `KCC_ASSERT_IMP(a_div_free, div_req.start, !div_stat.busy, "divider started while busy")
    `KCC_ASSERT_NXT(a_more_centres, out_xfer && !m_axis_tlast, m_axis_tvalid,
        "centre sequence broken")

endmodule

### tb/testbench.sv
// Testbench for the k-means colour clustering block: streams images, checks centres.
// Depends on kcc_pkg and the kmeans_color_clustering RTL; self-contained otherwise.
module testbench;
    import kcc_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        bit [3:0]  idx;
        bit [7:0]  blue;
        bit [7:0]  green;
        bit [7:0]  red;
        bit [9:0]  iters;
        bit        conv;
        bit        last;
    } centre_t;

    // Scoreboard: keeps its own model of the clustering engine and the queue
    // of centres it expects to see leave the block.
    class kmeans_scoreboard;
        bit [4:0]   k_reg;
        bit [9:0]   iter_reg;
        bit [31:0]  lfsr;
        bit [23:0]  image[$];
        centre_t    centres_due[$];
        int         errors;

        function new();
            k_reg = 5'd4;
            iter_reg = 10'd800;
            lfsr = 32'd1;
            errors = 0;
        endfunction

        function void write_reg(bit [1:0] addr, bit [31:0] val);
            if (addr == CFG_CLUSTER_COUNT)
            begin
                k_reg = val[4:0];
            end
            else if (addr == CFG_MAX_ITER)
            begin
                iter_reg = val[9:0];
            end
            else if (addr == CFG_RANDOM_SEED)
            begin
                lfsr = (val == 0) ? 32'd1 : val;
            end
        endfunction

        function bit [31:0] next_rand();
            bit lsb;
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb)
            begin
                lfsr = lfsr ^ 32'h8020_0003;
            end
            return lfsr;
        endfunction

        function int l1(bit [23:0] a, bit [23:0] b);
            int d;
            d = 0;
            for (int c = 0; c < 3; c++)
            begin
                int x, y;
                x = a[8*c +: 8];
                y = b[8*c +: 8];
                d += (x > y) ? x - y : y - x;
            end
            return d;
        endfunction

        // One accepted pixel; on the last one, run the whole clustering.
        function void note_pixel(bit [23:0] pix, bit last);
            int k, lim, iter, same;
            bit [23:0] ctr[16];
            bit [31:0] sums[16][3];
            int cnt[16];
            centre_t e;
            if (image.size() < 4096)
            begin
                image.insert(image.size(), pix);
            end
            if (!last)
            begin
                return;
            end
            k = (k_reg == 0) ? 1 : ((k_reg > 16) ? 16 : k_reg);
            lim = (iter_reg == 0) ? 1 : iter_reg;
            for (int r = 0; r < k; r++)
            begin
                ctr[r] = image[next_rand() % image.size()];
            end
            iter = 0;
            same = 0;
            while (iter < lim && same < k)
            begin
                iter++;
                same = 0;
                for (int r = 0; r < 16; r++)
                begin
                    cnt[r] = 0;
                    for (int c = 0; c < 3; c++)
                    begin
                        sums[r][c] = 0;
                    end
                end
                foreach (image[i])
                begin
                    int best, best_d, d;
                    best = 0;
                    best_d = 1 << 30;
                    for (int r = 0; r < k; r++)
                    begin
                        d = l1(image[i], ctr[r]);
                        if (d < best_d)
                        begin
                            best_d = d;
                            best = r;
                        end
                    end
                    for (int c = 0; c < 3; c++)
                    begin
                        sums[best][c] += image[i][8*c +: 8];
                    end
                    cnt[best]++;
                end
                for (int r = 0; r < k; r++)
                begin
                    bit [23:0] nc;
                    if (cnt[r] == 0)
                    begin
                        // empty cluster: reseed from three draws, b/g/r
                        nc[7:0] = 8'(next_rand());
                        nc[15:8] = 8'(next_rand());
                        nc[23:16] = 8'(next_rand());
                        ctr[r] = nc;
                    end
                    else
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            nc[8*c +: 8] = 8'(sums[r][c] / cnt[r]);
                        end
                        if (nc == ctr[r])
                        begin
                            same++;
                        end
                        ctr[r] = nc;
                    end
                end
            end
            for (int r = 0; r < k; r++)
            begin
                e.idx = 4'(r);
                e.blue = ctr[r][7:0];
                e.green = ctr[r][15:8];
                e.red = ctr[r][23:16];
                e.iters = 10'(iter);
                e.conv = (same >= k);
                e.last = (r == k - 1);
                centres_due.insert(centres_due.size(), e);
            end
            image.delete();
        endfunction

        function void check_centre(centre_t got);
            centre_t w;
            if (centres_due.size() == 0)
            begin
                $error("unexpected centre transfer, index %0d", got.idx);
                errors++;
                return;
            end
            w = centres_due.pop_front();
            if (got.idx != w.idx)
            begin
                $error("cluster_index: expected %0d, actual %0d", w.idx, got.idx);
                errors++;
            end
            if (got.blue != w.blue)
            begin
                $error("centre_blue: expected %0d, actual %0d", w.blue, got.blue);
                errors++;
            end
            if (got.green != w.green)
            begin
                $error("centre_green: expected %0d, actual %0d", w.green, got.green);
                errors++;
            end
            if (got.red != w.red)
            begin
                $error("centre_red: expected %0d, actual %0d", w.red, got.red);
                errors++;
            end
            if (got.iters != w.iters)
            begin
                $error("iterations_used: expected %0d, actual %0d", w.iters, got.iters);
                errors++;
            end
            if (got.conv != w.conv)
            begin
                $error("converged: expected %0d, actual %0d", w.conv, got.conv);
                errors++;
            end
            if (got.last != w.last)
            begin
                $error("last_centre: expected %0d, actual %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata;   // blue, green, red
    logic                 s_axis_tlast;   // last pixel of the image
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // index, blue, green, red, iters, converged, pad
    logic                 m_axis_tlast;   // last centre of the run
    logic                 cfg_we;
    logic [1:0]           cfg_addr;
    logic [SEED_W-1:0]    cfg_wdata;

    kmeans_scoreboard sb;
    int  src_idle_pct;    // chance per cycle that the pixel source pauses
    int  snk_idle_pct;    // chance per cycle that the centre sink stalls
    bit  hold_req;        // asks the sink for one long stall
    bit  hold_on;         // long stall in progress
    int  hold_cnt;

    kmeans_color_clustering u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Long sink stall, counted in cycles once requested.
    initial
    begin
        hold_on = 1'b0;
        hold_cnt = 0;
        wait (hold_req);
        hold_on = 1'b1;
        while (hold_cnt < 3000)
        begin
            @(negedge clk);
            hold_cnt++;
        end
        hold_on = 1'b0;
    end

    // Sink: ready changes on the falling edge; the long hold wins over
    // the random stall pattern.
    always @(negedge clk)
    begin
        if (hold_on)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Centre transfers are checked at the rising edge they complete on.
    always @(posedge clk)
    begin
        centre_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.idx = m_axis_tdata[3:0];
            got.blue = m_axis_tdata[11:4];
            got.green = m_axis_tdata[19:12];
            got.red = m_axis_tdata[27:20];
            got.iters = m_axis_tdata[37:28];
            got.conv = m_axis_tdata[38];
            got.last = m_axis_tlast;
            sb.check_centre(got);
        end
    end

    // Offer one pixel, with random pauses first; note it when it transfers.
    task automatic send_pixel(bit [23:0] pix, bit last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pix;
        s_axis_tlast = last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_pixel(pix, last);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Config writes only happen with the block idle and all centres out.
    task automatic write_reg(bit [1:0] addr, bit [31:0] val);
        while (sb.centres_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(addr, val);
    endtask

    task automatic send_image(int n, bit extremes);
        bit [23:0] pix;
        for (int i = 0; i < n; i++)
        begin
            if (extremes)
            begin
                pix = {$urandom_range(1) ? 8'hFF : 8'h00,
                       $urandom_range(1) ? 8'hFF : 8'h00,
                       $urandom_range(1) ? 8'hFF : 8'h00};
            end
            else
            begin
                pix = 24'($urandom());
            end
            send_pixel(pix, i == n - 1);
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int sent;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_CLUSTER_COUNT;
        cfg_wdata = '0;
        hold_req = 1'b0;
        src_idle_pct = 6;
        snk_idle_pct = 76;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: odd register values and extreme pixels
        write_reg(CFG_MAX_ITER, 10);
        send_image(1, 1);                   // one pixel, k=4: empty clusters
        write_reg(CFG_CLUSTER_COUNT, 0);    // k zero acts as one
        write_reg(CFG_MAX_ITER, 1023);
        write_reg(CFG_RANDOM_SEED, 0);      // zero seed loads as one
        send_image(4, 1);
        write_reg(CFG_CLUSTER_COUNT, 31);   // saturates to 16
        write_reg(CFG_MAX_ITER, 0);         // limit zero acts as one
        write_reg(CFG_RANDOM_SEED, 32'hFFFF_FFFF);
        send_image(5, 1);
        write_reg(CFG_CLUSTER_COUNT, 17);
        write_reg(CFG_MAX_ITER, 3);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        send_image(3, 1);
        write_reg(CFG_CLUSTER_COUNT, 2);
        hold_req = 1'b1;                    // long sink stall during this run
        send_image(6, 0);
        send_image(5, 0);                   // offered while the centres are held

        // random images, three idle patterns
        sent = 0;
        while (sent < 400)
        begin
            int n;
            if (sent >= 260)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (sent >= 130)
            begin
                src_idle_pct = 76;
                snk_idle_pct = 6;
            end
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_CLUSTER_COUNT, $urandom_range(31));
            end
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_MAX_ITER, $urandom_range(12));
            end
            if ($urandom_range(4) == 0)
            begin
                write_reg(CFG_RANDOM_SEED, $urandom());
            end
            n = $urandom_range(1, 12);
            send_image(n, $urandom_range(4) == 0);
            sent += n;
        end

        while (sb.centres_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
